/* design/unicycle_rollout_cost_eval_defines.svh */
// Assertion macros shared by the rollout cost evaluator modules.
// No dependencies; each user module must have clk and rst_n in scope.
`ifndef UNICYCLE_ROLLOUT_COST_EVAL_DEFINES_SVH
`define UNICYCLE_ROLLOUT_COST_EVAL_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define URCE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("urce same-cycle check failed");

// Next-cycle implication, ignored while reset is asserted.
`define URCE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("urce next-cycle check failed");

`endif

/* design/urce_pkg.sv */
// Shared types, opcodes and constants for the rollout cost evaluator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package urce_pkg;

  localparam int CNT_W = 5;

  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_ACCEPT = 4'd1;
  localparam logic [3:0] OP_INIT   = 4'd2;
  localparam logic [3:0] OP_REM    = 4'd3;
  localparam logic [3:0] OP_WRAP   = 4'd4;
  localparam logic [3:0] OP_FOLD   = 4'd5;
  localparam logic [3:0] OP_CORD   = 4'd6;
  localparam logic [3:0] OP_MULX   = 4'd7;
  localparam logic [3:0] OP_MULY   = 4'd8;
  localparam logic [3:0] OP_POSY   = 4'd9;
  localparam logic [3:0] OP_SQ     = 4'd10;
  localparam logic [3:0] OP_ACC    = 4'd11;
  localparam logic [3:0] OP_FINISH = 4'd12;

  localparam logic [2:0] REG_START_X = 3'd0;
  localparam logic [2:0] REG_START_Y = 3'd1;
  localparam logic [2:0] REG_START_V = 3'd2;
  localparam logic [2:0] REG_GOAL_X  = 3'd3;
  localparam logic [2:0] REG_GOAL_Y  = 3'd4;
  localparam logic [2:0] REG_CHASE_X = 3'd5;
  localparam logic [2:0] REG_CHASE_Y = 3'd6;
  localparam int         NUM_REGS    = 7;

  localparam logic signed [34:0] Q30_PI      = 35'sd3373259426;
  localparam logic signed [34:0] Q30_HALF_PI = 35'sd1686629713;
  localparam logic signed [34:0] Q30_TWO_PI  = 35'sd6746518852;
  localparam logic [33:0]        Q30_TWO_PI_U = 34'd6746518852;
  localparam logic signed [33:0] Q30_GAIN    = 34'sd652032875;

  localparam logic signed [23:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] POS_MIN = -24'sh800000;

  typedef struct packed {
    logic [3:0]       op;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic out_hold;
  } stat_t;

  function automatic logic signed [34:0] atan_q30(input logic [CNT_W-1:0] i);
    logic signed [34:0] v;
    case (i)
      5'd0:    v = 35'sd843314857;
      5'd1:    v = 35'sd497837830;
      5'd2:    v = 35'sd263043837;
      5'd3:    v = 35'sd133525159;
      5'd4:    v = 35'sd67021687;
      5'd5:    v = 35'sd33543516;
      5'd6:    v = 35'sd16775851;
      5'd7:    v = 35'sd8388437;
      5'd8:    v = 35'sd4194283;
      5'd9:    v = 35'sd2097149;
      5'd10:   v = 35'sd1048576;
      5'd11:   v = 35'sd524288;
      5'd12:   v = 35'sd262144;
      5'd13:   v = 35'sd131072;
      5'd14:   v = 35'sd65536;
      5'd15:   v = 35'sd32768;
      5'd16:   v = 35'sd16384;
      5'd17:   v = 35'sd8192;
      5'd18:   v = 35'sd4096;
      5'd19:   v = 35'sd2048;
      5'd20:   v = 35'sd1024;
      5'd21:   v = 35'sd512;
      5'd22:   v = 35'sd256;
      5'd23:   v = 35'sd128;
      default: v = 35'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
    logic signed [23:0] r;
    if (v > 28'(POS_MAX)) begin
      r = POS_MAX;
    end else if (v < 28'(POS_MIN)) begin
      r = POS_MIN;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/urce_ctrl.sv */
// Sequencing state machine of the rollout cost evaluator.
// Depends on urce_pkg and unicycle_rollout_cost_eval_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "unicycle_rollout_cost_eval_defines.svh"

module urce_ctrl #(
  parameter int REM_STEPS = 1,
  parameter int CORD_N    = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  urce_pkg::stat_t      st,
  output urce_pkg::cmd_t       cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INIT = 4'd1;
  localparam logic [3:0] S_REM  = 4'd2;
  localparam logic [3:0] S_WRAP = 4'd3;
  localparam logic [3:0] S_FOLD = 4'd4;
  localparam logic [3:0] S_CORD = 4'd5;
  localparam logic [3:0] S_MX   = 4'd6;
  localparam logic [3:0] S_MY   = 4'd7;
  localparam logic [3:0] S_PY   = 4'd8;
  localparam logic [3:0] S_SQ   = 4'd9;
  localparam logic [3:0] S_ACC  = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  localparam logic [urce_pkg::CNT_W-1:0] REM_TOP  = urce_pkg::CNT_W'(REM_STEPS - 1);
  localparam logic [urce_pkg::CNT_W-1:0] CORD_TOP = urce_pkg::CNT_W'(CORD_N - 1);
  localparam logic [urce_pkg::CNT_W-1:0] SQ_TOP   = urce_pkg::CNT_W'(3);

  logic [3:0]                  state_r, state_nxt;
  logic [urce_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd.op    = urce_pkg::OP_NONE;
    cmd.cnt   = cnt_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = urce_pkg::OP_ACCEPT;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd.op    = urce_pkg::OP_INIT;
        cnt_nxt   = REM_TOP;
        state_nxt = S_REM;
      end
      S_REM: begin
        cmd.op = urce_pkg::OP_REM;
        if (cnt_r == '0) begin
          state_nxt = S_WRAP;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_WRAP: begin
        cmd.op    = urce_pkg::OP_WRAP;
        state_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.op    = urce_pkg::OP_FOLD;
        cnt_nxt   = '0;
        state_nxt = S_CORD;
      end
      S_CORD: begin
        cmd.op = urce_pkg::OP_CORD;
        if (cnt_r == CORD_TOP) begin
          state_nxt = S_MX;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_MX: begin
        cmd.op    = urce_pkg::OP_MULX;
        state_nxt = S_MY;
      end
      S_MY: begin
        cmd.op    = urce_pkg::OP_MULY;
        state_nxt = S_PY;
      end
      S_PY: begin
        cmd.op    = urce_pkg::OP_POSY;
        cnt_nxt   = '0;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.op    = urce_pkg::OP_SQ;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op = urce_pkg::OP_ACC;
        if (cnt_r == SQ_TOP) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_SQ;
        end
      end
      S_DONE: begin
        if (!st.out_hold) begin
          cmd.op    = urce_pkg::OP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `URCE_ASSERT_NXT(a_accept_starts, in_valid && in_ready, state_r == S_INIT)
  `URCE_ASSERT_IMP(a_cord_in_range, state_r == S_CORD, cnt_r <= CORD_TOP)
  `URCE_ASSERT_IMP(a_finish_free, cmd.op == urce_pkg::OP_FINISH, !st.out_hold)
  `URCE_ASSERT_NXT(a_done_leaves, (state_r == S_DONE) && !st.out_hold, state_r == S_IDLE)

endmodule

`default_nettype wire

/* design/urce_dp.sv */
// Datapath of the rollout cost evaluator: registers, CORDIC, shared multiplier.
// Depends on urce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module urce_dp #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  urce_pkg::cmd_t          cmd,
  output urce_pkg::stat_t         st,
  input  wire logic signed [23:0] in_step_accel,
  input  wire logic signed [18:0] in_step_heading,
  input  wire logic               in_last_step,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [23:0]      out_point_x,
  output logic signed [23:0]      out_point_y,
  output logic [31:0]             out_chaser_dist_sq,
  output logic [35:0]             out_path_cost,
  output logic                    out_run_done,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [23:0]        cfg_wdata
);

  localparam int ZW    = 49 - FRAC_BITS;
  localparam int RW    = (ZW > 35) ? ZW : 35;
  localparam int SUM_W = 52;

  logic [23:0]        cfg_r [urce_pkg::NUM_REGS];
  logic signed [23:0] accel_r;
  logic signed [18:0] head_r;
  logic               last_r;
  logic signed [23:0] cur_x_r, cur_y_r, cur_v_r;
  logic [35:0]        cost_r;
  logic               run_open_r;
  logic signed [26:0] disp_r;
  logic               zneg_r;
  logic [RW-1:0]      zmag_r;
  logic signed [34:0] z_r;
  logic               flip_r;
  logic signed [33:0] cx_r, cy_r;
  logic signed [58:0] prod_r;
  logic [SUM_W-1:0]   acc_c_r, acc_g_r;
  logic               out_valid_r;
  logic signed [23:0] out_x_r, out_y_r;
  logic [31:0]        out_dc_r;
  logic [35:0]        out_cost_r;
  logic               out_done_r;

  logic signed [ZW-1:0] zfull;
  logic [ZW-1:0]        zabs;
  logic [RW-1:0]        cand;
  logic signed [34:0]   zs, zw;
  logic signed [33:0]   xs, ys, cxf, cyf;
  logic signed [31:0]   mul_a;
  logic signed [26:0]   mul_b;
  logic signed [58:0]   prod_nxt, step_full;
  logic signed [27:0]   pos_sum;
  logic signed [24:0]   dsel;
  logic signed [25:0]   vsum;
  logic [SUM_W-1:0]     sq_sh, cost_sum;

  assign st.out_hold = out_valid_r && !out_ready;

  always_comb begin
    zfull = ZW'(head_r) <<< (30 - FRAC_BITS);
    zabs  = zfull[ZW-1] ? ZW'(-zfull) : ZW'(zfull);
    cand  = RW'(urce_pkg::Q30_TWO_PI_U) << cmd.cnt;
    zs    = zneg_r ? -$signed({1'b0, zmag_r[33:0]}) : $signed({1'b0, zmag_r[33:0]});
    zw    = zs;
    if (zs > urce_pkg::Q30_PI) begin
      zw = zs - urce_pkg::Q30_TWO_PI;
    end else if (zs < -urce_pkg::Q30_PI) begin
      zw = zs + urce_pkg::Q30_TWO_PI;
    end
    xs  = cx_r >>> cmd.cnt;
    ys  = cy_r >>> cmd.cnt;
    cxf = flip_r ? -cx_r : cx_r;
    cyf = flip_r ? -cy_r : cy_r;
    case (cmd.cnt[1:0])
      2'd0:    dsel = 25'(cur_x_r) - 25'($signed(cfg_r[urce_pkg::REG_CHASE_X]));
      2'd1:    dsel = 25'(cur_y_r) - 25'($signed(cfg_r[urce_pkg::REG_CHASE_Y]));
      2'd2:    dsel = 25'(cur_x_r) - 25'($signed(cfg_r[urce_pkg::REG_GOAL_X]));
      default: dsel = 25'(cur_y_r) - 25'($signed(cfg_r[urce_pkg::REG_GOAL_Y]));
    endcase
    case (cmd.op)
      urce_pkg::OP_MULX: begin
        mul_a = cxf[31:0];
        mul_b = disp_r;
      end
      urce_pkg::OP_MULY: begin
        mul_a = cyf[31:0];
        mul_b = disp_r;
      end
      default: begin
        mul_a = 32'(dsel);
        mul_b = 27'(dsel);
      end
    endcase
    prod_nxt  = mul_a * mul_b;
    // Round half up, then floor shift by 33.
    step_full = (prod_r + 59'sh100000000) >>> 33;
    pos_sum   = (cmd.op == urce_pkg::OP_MULY)
                ? 28'(cur_x_r) + 28'($signed(step_full[25:0]))
                : 28'(cur_y_r) + 28'($signed(step_full[25:0]));
    vsum      = 26'(cur_v_r) + ((26'(accel_r) + 26'sd1) >>> 1);
    sq_sh     = SUM_W'(prod_r[57:0] >> FRAC_BITS);
    cost_sum  = SUM_W'(cost_r) + acc_g_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < urce_pkg::NUM_REGS; i++) begin
        cfg_r[i] <= '0;
      end
    end else if (cfg_we && (cfg_index <= urce_pkg::REG_CHASE_Y)) begin
      cfg_r[cfg_index] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      cur_v_r     <= '0;
      cost_r      <= '0;
      run_open_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == urce_pkg::OP_FINISH) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        urce_pkg::OP_ACCEPT: begin
          accel_r <= in_step_accel;
          head_r  <= in_step_heading;
          last_r  <= in_last_step;
          if (!run_open_r) begin
            cur_x_r <= $signed(cfg_r[urce_pkg::REG_START_X]);
            cur_y_r <= $signed(cfg_r[urce_pkg::REG_START_Y]);
            cur_v_r <= $signed(cfg_r[urce_pkg::REG_START_V]);
            cost_r  <= '0;
          end
        end
        urce_pkg::OP_INIT: begin
          disp_r  <= (27'(cur_v_r) <<< 2) + 27'(accel_r);
          cur_v_r <= urce_pkg::sat24(28'(vsum));
          zneg_r  <= zfull[ZW-1];
          zmag_r  <= RW'(zabs);
        end
        urce_pkg::OP_REM: begin
          if (zmag_r >= cand) begin
            zmag_r <= zmag_r - cand;
          end
        end
        urce_pkg::OP_WRAP: begin
          z_r <= zw;
        end
        urce_pkg::OP_FOLD: begin
          cx_r <= urce_pkg::Q30_GAIN;
          cy_r <= '0;
          if (z_r > urce_pkg::Q30_HALF_PI) begin
            z_r    <= z_r - urce_pkg::Q30_PI;
            flip_r <= 1'b1;
          end else if (z_r < -urce_pkg::Q30_HALF_PI) begin
            z_r    <= z_r + urce_pkg::Q30_PI;
            flip_r <= 1'b1;
          end else begin
            flip_r <= 1'b0;
          end
        end
        urce_pkg::OP_CORD: begin
          if (!z_r[34]) begin
            cx_r <= cx_r - ys;
            cy_r <= cy_r + xs;
            z_r  <= z_r - urce_pkg::atan_q30(cmd.cnt);
          end else begin
            cx_r <= cx_r + ys;
            cy_r <= cy_r - xs;
            z_r  <= z_r + urce_pkg::atan_q30(cmd.cnt);
          end
        end
        urce_pkg::OP_MULX: begin
          prod_r <= prod_nxt;
        end
        urce_pkg::OP_MULY: begin
          prod_r  <= prod_nxt;
          cur_x_r <= urce_pkg::sat24(pos_sum);
        end
        urce_pkg::OP_POSY: begin
          cur_y_r <= urce_pkg::sat24(pos_sum);
        end
        urce_pkg::OP_SQ: begin
          prod_r <= prod_nxt;
        end
        urce_pkg::OP_ACC: begin
          case (cmd.cnt[1:0])
            2'd0:    acc_c_r <= sq_sh;
            2'd1:    acc_c_r <= acc_c_r + sq_sh;
            2'd2:    acc_g_r <= sq_sh;
            default: acc_g_r <= acc_g_r + sq_sh;
          endcase
        end
        urce_pkg::OP_FINISH: begin
          out_x_r     <= cur_x_r;
          out_y_r     <= cur_y_r;
          out_dc_r    <= (acc_c_r > SUM_W'(32'hFFFFFFFF)) ? 32'hFFFFFFFF : acc_c_r[31:0];
          if (cost_sum > SUM_W'(36'hFFFFFFFFF)) begin
            cost_r     <= 36'hFFFFFFFFF;
            out_cost_r <= 36'hFFFFFFFFF;
          end else begin
            cost_r     <= cost_sum[35:0];
            out_cost_r <= cost_sum[35:0];
          end
          out_done_r <= last_r;
          run_open_r <= !last_r;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_point_x        = out_x_r;
  assign out_point_y        = out_y_r;
  assign out_chaser_dist_sq = out_dc_r;
  assign out_path_cost      = out_cost_r;
  assign out_run_done       = out_done_r;

endmodule

`default_nettype wire

/* design/unicycle_rollout_cost_eval.sv */
// Top level of the unicycle rollout cost evaluator.
// Depends on urce_pkg, urce_ctrl and urce_dp.
//
//   Channel | Signals                                         | Direction
//   --------+-------------------------------------------------+----------
//   in      | in_valid/in_ready, step accel, heading, last    | input word
//   out     | out_valid/out_ready, point, distances, run_done | result word
//   cfg     | cfg_we, cfg_index, cfg_wdata                    | register write
//
// Each input word passes through R remainder steps and min(CORDIC_STEPS, 24) rotation steps,
// where R is 1 for FRAC_BITS of 16 and above and 17 - FRAC_BITS below; the serial CORDIC
// and the single shared multiplier handle every word. The sequencer returns to idle after
// each result, so the next word is only taken once the last one is through.
// Reset is synchronous and active low; it clears the registers, the running state and
// the result valid flag. A word is accepted whenever the sequencer is idle, even while a
// previous result waits on out_ready; the sequencer only stalls at its final step.
`timescale 1ns / 1ps
`default_nettype none

module unicycle_rollout_cost_eval #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [23:0] in_step_accel,
  input  wire logic signed [18:0] in_step_heading,
  input  wire logic               in_last_step,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [23:0]      out_point_x,
  output logic signed [23:0]      out_point_y,
  output logic [31:0]             out_chaser_dist_sq,
  output logic [35:0]             out_path_cost,
  output logic                    out_run_done,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [23:0]        cfg_wdata
);

  // The heading, scaled to Q30, is ZW bits wide; the remainder against two pi is taken
  // by restoring subtraction of shifted copies of two pi, one per cycle.
  localparam int ZW        = 49 - FRAC_BITS;
  localparam int REM_STEPS = (ZW > 33) ? (ZW - 32) : 1;
  // The arctangent table holds 24 entries, so the rotation count stops there.
  localparam int CORD_N    = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

  urce_pkg::cmd_t  cmd;
  urce_pkg::stat_t st;

  // The controller walks each word through reduction, rotation, the two position
  // products and the four squared distances.
  urce_ctrl #(
    .REM_STEPS (REM_STEPS),
    .CORD_N    (CORD_N)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath holds the registers, the pose, the cost and the result register.
  urce_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_step_accel      (in_step_accel),
    .in_step_heading    (in_step_heading),
    .in_last_step       (in_last_step),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_point_x        (out_point_x),
    .out_point_y        (out_point_y),
    .out_chaser_dist_sq (out_chaser_dist_sq),
    .out_path_cost      (out_path_cost),
    .out_run_done       (out_run_done),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for the unicycle rollout cost evaluator.
// Depends on urce_pkg and the unicycle_rollout_cost_eval RTL only.
// A clocked driver and monitor exchange words with the block; a built-in predictor checks each result.
`timescale 1ns / 1ps

module tb_top;

  // The write port accepts index 7, which addresses no register.
  localparam logic [2:0] REG_UNUSED = 3'd7;
  // Cycles from acceptance to result, rounded up; used before writes and at the end.
  localparam int SETTLE_CYCLES = 48;

  typedef struct {
    logic signed [23:0] accel;
    logic signed [18:0] heading;
    logic               last;
  } step_word_t;

  typedef struct {
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic [31:0]        chase;
    logic [35:0]        cost;
    logic               done;
  } point_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [23:0] in_step_accel = '0;
  logic signed [18:0] in_step_heading = '0;
  logic in_last_step = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [23:0] out_point_x;
  logic signed [23:0] out_point_y;
  logic [31:0] out_chaser_dist_sq;
  logic [35:0] out_path_cost;
  logic out_run_done;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_wdata = '0;

  unicycle_rollout_cost_eval dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Words waiting to be sent, and the results the predictor expects.
  step_word_t    pending_steps[$];
  point_result_t expected_points[$];
  int  mismatches = 0;
  bit  calm = 1'b0;      // when set, neither side idles
  bit  in_fire = 1'b0;
  bit  out_fire = 1'b0;

  // Predictor copy of the registers and the runner state.
  logic signed [23:0] reg_copy[urce_pkg::NUM_REGS];
  longint run_x = 0, run_y = 0, run_v = 0;
  longint run_cost = 0;
  bit     run_open = 1'b0;

  function automatic longint clamp_pos(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic longint sq_dist(longint ax, longint ay, longint bx, longint by);
    longint dx, dy;
    dx = ax - bx;
    dy = ay - by;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return ((dx * dx) >> 16) + ((dy * dy) >> 16);
  endfunction

  // Advances the runner by one step and returns the point it reports.
  function automatic point_result_t advance_runner(step_word_t w);
    point_result_t r;
    longint z, cx, cy, xs, ys, disp, dc, dg;
    bit flip;
    if (!run_open) begin
      run_x = reg_copy[urce_pkg::REG_START_X];
      run_y = reg_copy[urce_pkg::REG_START_Y];
      run_v = reg_copy[urce_pkg::REG_START_V];
      run_cost = 0;
    end
    // The heading goes to Q30, is brought into [-pi, pi] and then folded into
    // [-pi/2, pi/2]; folding negates both sin and cos.
    z = longint'(w.heading) * 64'sd16384;
    z = z % longint'(urce_pkg::Q30_TWO_PI);
    if (z > longint'(urce_pkg::Q30_PI)) z -= longint'(urce_pkg::Q30_TWO_PI);
    if (z < -longint'(urce_pkg::Q30_PI)) z += longint'(urce_pkg::Q30_TWO_PI);
    flip = 1'b0;
    if (z > longint'(urce_pkg::Q30_HALF_PI)) begin
      z -= longint'(urce_pkg::Q30_PI);
      flip = 1'b1;
    end else if (z < -longint'(urce_pkg::Q30_HALF_PI)) begin
      z += longint'(urce_pkg::Q30_PI);
      flip = 1'b1;
    end
    cx = longint'(urce_pkg::Q30_GAIN);
    cy = 0;
    for (int i = 0; i < 16; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (z >= 0) begin
        cx -= ys; cy += xs; z -= longint'(urce_pkg::atan_q30(i[4:0]));
      end else begin
        cx += ys; cy -= xs; z += longint'(urce_pkg::atan_q30(i[4:0]));
      end
    end
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end
    disp = 4 * run_v + longint'(w.accel);
    run_x = clamp_pos(run_x + ((cx * disp + (64'sd1 <<< 32)) >>> 33));
    run_y = clamp_pos(run_y + ((cy * disp + (64'sd1 <<< 32)) >>> 33));
    run_v = clamp_pos(run_v + ((longint'(w.accel) + 1) >>> 1));
    dc = sq_dist(run_x, run_y, reg_copy[urce_pkg::REG_CHASE_X],
                 reg_copy[urce_pkg::REG_CHASE_Y]);
    if (dc > 64'sh0FFFFFFFF) dc = 64'sh0FFFFFFFF;
    dg = sq_dist(run_x, run_y, reg_copy[urce_pkg::REG_GOAL_X],
                 reg_copy[urce_pkg::REG_GOAL_Y]);
    run_cost += dg;
    if (run_cost > 64'sh0FFFFFFFFF) run_cost = 64'sh0FFFFFFFFF;
    run_open = !w.last;
    r.px = run_x[23:0];
    r.py = run_y[23:0];
    r.chase = dc[31:0];
    r.cost = run_cost[35:0];
    r.done = w.last;
    return r;
  endfunction

  task automatic report(string field, longint got, longint want);
    mismatches++;
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
  endtask

  // Driver: a word is put up at the falling edge and held until accepted.
  always @(negedge clk) begin
    static int gap = 0;
    step_word_t w;
    if (rst_n && !(in_valid && !in_fire)) begin
      if (gap > 0) begin
        gap--;
        in_valid <= 1'b0;
      end else if (pending_steps.size() > 0) begin
        w = pending_steps.pop_front();
        in_step_accel <= w.accel;
        in_step_heading <= w.heading;
        in_last_step <= w.last;
        in_valid <= 1'b1;
        gap = calm ? 0 : $urandom_range(0, 15);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: after each result it holds ready low for a drawn number of cycles.
  always @(negedge clk) begin
    static int stall = 0;
    if (rst_n) begin
      if (out_fire) stall = calm ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on each accepted word and checks each accepted result.
  always @(posedge clk) begin
    step_word_t    w;
    point_result_t e;
    in_fire <= rst_n && in_valid && in_ready;
    out_fire <= rst_n && out_valid && out_ready;
    if (rst_n && in_valid && in_ready) begin
      w.accel = in_step_accel;
      w.heading = in_step_heading;
      w.last = in_last_step;
      expected_points.push_back(advance_runner(w));
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_points.size() == 0) begin
        report("unexpected result", 0, 0);
      end else begin
        e = expected_points.pop_front();
        if (out_point_x !== e.px) report("point_x", out_point_x, e.px);
        if (out_point_y !== e.py) report("point_y", out_point_y, e.py);
        if (out_chaser_dist_sq !== e.chase) report("chaser_dist_sq", out_chaser_dist_sq, e.chase);
        if (out_path_cost !== e.cost) report("path_cost", out_path_cost, e.cost);
        if (out_run_done !== e.done) report("run_done", out_run_done, e.done);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx < urce_pkg::NUM_REGS) reg_copy[idx] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_step(int accel, int heading, bit last);
    step_word_t w;
    w.accel = accel[23:0];
    w.heading = heading[18:0];
    w.last = last;
    pending_steps.push_back(w);
  endtask

  // Waits until the block has drained and then for the pipeline to settle.
  task automatic drain();
    while (pending_steps.size() > 0 || in_valid || expected_points.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic int draw_accel();
    case ($urandom_range(0, 3))
      0: return $signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8;
      1: return $signed($urandom_range(0, 20'hFFFFF)) - 524288;
      2: return $signed($urandom_range(0, 12'hFFF)) - 2048;
      default: return $urandom_range(0, 1) ? 8388607 : -8388608;
    endcase
  endfunction

  function automatic int draw_heading();
    return $signed($urandom_range(0, 19'h7FFFF) << 13) >>> 13;
  endfunction

  // Stimulus: directed words, then phases of random runs with fresh register settings.
  initial begin
    int run_len;
    for (int i = 0; i < urce_pkg::NUM_REGS; i++) reg_copy[i] = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // An unmapped index must leave every register alone.
    write_reg(REG_UNUSED, 24'hFFFFFF);
    write_reg(urce_pkg::REG_START_X, 24'h7FFFFF);
    write_reg(urce_pkg::REG_START_Y, 24'h800000);
    write_reg(urce_pkg::REG_START_V, 24'h7FFFFF);
    write_reg(urce_pkg::REG_GOAL_X, 24'h800000);
    write_reg(urce_pkg::REG_GOAL_Y, 24'h7FFFFF);
    write_reg(urce_pkg::REG_CHASE_X, 24'h800000);
    write_reg(urce_pkg::REG_CHASE_Y, 24'h7FFFFF);

    // Directed: heading extremes, the fold boundaries near +-pi/2 and +-pi,
    // accelerations at both ends so position and speed saturate, single-word runs,
    // and a long run with a far goal so the cost saturates.
    push_step(8388607, 0, 1'b0);
    push_step(8388607, 0, 1'b0);
    push_step(-8388608, 262143, 1'b0);
    push_step(-8388608, -262144, 1'b1);
    push_step(0, 102943, 1'b1);
    push_step(0, 102945, 1'b1);
    push_step(0, -102945, 1'b1);
    push_step(1, 205887, 1'b0);
    push_step(-1, -205887, 1'b0);
    push_step(-1, 205888, 1'b1);
    for (int i = 0; i < 12; i++) push_step(8388607, 205887, i == 11);
    push_step(0, 0, 1'b1);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      calm = (phase % 3 == 1);
      for (int r = 0; r < urce_pkg::NUM_REGS; r++) begin
        case (phase)
          0: write_reg(r[2:0], 24'h000000);
          1: write_reg(r[2:0], 24'h7FFFFF);
          2: write_reg(r[2:0], 24'h800000);
          3: write_reg(r[2:0], (r % 2) ? 24'h800000 : 24'h7FFFFF);
          4, 5: write_reg(r[2:0], 24'($urandom_range(0, 24'hFFFFFF)));
          default: write_reg(r[2:0], 24'($urandom_range(0, 24'h1FFFFF) - 24'h100000));
        endcase
      end
      for (int n = 0; n < 190; ) begin
        if (phase == 2 && n >= 60 && n < 70) begin
          // Hold the sender back until every result so far has come in.
          while (pending_steps.size() > 0 || in_valid || expected_points.size() > 0)
            @(negedge clk);
          n = 70;
        end
        if ($urandom_range(0, 7) == 0) begin
          // Noise: an isolated word with a random end marker.
          push_step(draw_accel(), draw_heading(), $urandom_range(0, 1) == 1);
          n++;
        end else begin
          run_len = $urandom_range(1, 12);
          for (int k = 0; k < run_len; k++) push_step(draw_accel(), draw_heading(), k == run_len - 1);
          n += run_len;
        end
        while (pending_steps.size() > 8) @(negedge clk);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
